### design/prxw_pkg.sv
package prxw_pkg;

  localparam int RING_COUNT = 6;
  localparam int POS_W      = 5;
  localparam int IDX_W      = 3;

  typedef logic [7:0]       byte_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [IDX_W-1:0] ring_idx_t;

  localparam pos_t RING_LEN [RING_COUNT] = '{
    5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29
  };

  localparam ring_idx_t LAST_RING = 3'd5;

endpackage

### design/prime_ring_xor_whitener.sv
// path: an accepted item is registered in s1 alongside its ring ram reads, then pushed into the output queue
// throughput: one item per cycle while the output queue has room; each ring sits in
// its own ring ram, read once and written at most once per cycle, and a 3-entry output queue absorbs stalls
// reset: positions zero, ring 0 current, countdown 11, entry valid bits cleared
// so every ring entry reads as zero until written; in_ready is high right after
module prime_ring_xor_whitener import prxw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_byte,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_byte
);

  pos_t      pos [RING_COUNT];
  ring_idx_t cur;
  pos_t      cnt;
  pos_t      cnt_dec;
  ring_idx_t cur_inc;

  logic      s1_valid;
  byte_t     s1_in;
  ring_idx_t s1_cur;
  pos_t      s1_wpos;

  byte_t     rbyte [RING_COUNT];
  byte_t     acc;
  byte_t     wbyte;
  logic [1:0] q_count;
  logic      accept;

  // queue plus item in flight must leave room for the new item
  assign in_ready = ({1'b0, q_count} + {2'b00, s1_valid}) < 3'd3;
  assign accept   = in_valid && in_ready;
  assign cnt_dec  = cnt - 5'd1;
  assign cur_inc  = (cur == LAST_RING) ? 3'd0 : cur + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RING_COUNT; r++) begin
        pos[r] <= '0;
      end
      cur      <= '0;
      cnt      <= RING_LEN[0];
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        for (int r = 0; r < RING_COUNT; r++) begin
          pos[r] <= (pos[r] == '0) ? RING_LEN[r] - 5'd1 : pos[r] - 5'd1;
        end
        if (cnt_dec == '0) begin
          cur <= cur_inc;
          cnt <= RING_LEN[cur_inc];
        end else begin
          cnt <= cnt_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in   <= in_byte;
      s1_cur  <= cur;
      s1_wpos <= pos[cur];
    end
  end

  for (genvar g = 0; g < RING_COUNT; g++) begin : g_ring
    localparam int DEPTH = int'(RING_LEN[g]);
    localparam int AW    = $clog2(DEPTH);

    logic [DEPTH-1:0] vld;
    logic             rd_vld;
    byte_t            rdata;
    logic             we;

    assign we = s1_valid && (s1_cur == 3'(g));

    prxw_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(s1_wpos[AW-1:0]),
      .wdata(wbyte),
      .raddr(pos[g][AW-1:0]),
      .rdata(rdata)
    );

    // consecutive items never touch the same entry, so no bypass is needed
    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= '0;
      end else if (we) begin
        vld[s1_wpos[AW-1:0]] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      rd_vld <= vld[pos[g][AW-1:0]];
    end

    assign rbyte[g] = rd_vld ? rdata : 8'd0;
  end

  always_comb begin
    acc = '0;
    for (int r = 0; r < RING_COUNT; r++) begin
      acc = acc ^ rbyte[r];
    end
  end

  assign wbyte = acc ^ s1_in;

  prxw_ofifo u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .push     (s1_valid),
    .push_data(acc),
    .pop_ready(out_ready),
    .pop_valid(out_valid),
    .pop_data (out_byte),
    .count    (q_count)
  );

endmodule

### design/prxw_ram.sv
module prxw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/prxw_ofifo.sv
module prxw_ofifo import prxw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  byte_t      push_data,
  input  logic       pop_ready,
  output logic       pop_valid,
  output byte_t      pop_data,
  output logic [1:0] count
);

  localparam logic [1:0] LAST_SLOT = 2'd2;

  byte_t      slot [3];
  logic [1:0] head;
  logic [1:0] tail;
  logic       pop;

  assign pop_valid = (count != 2'd0);
  assign pop_data  = slot[head];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= (tail == LAST_SLOT) ? 2'd0 : tail + 2'd1;
      end
      if (pop) begin
        head <= (head == LAST_SLOT) ? 2'd0 : head + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import prxw_pkg::*;

  localparam int PHASE_ITEMS = 500;
  localparam int HOLD_CYCLES = 300;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  byte_t in_byte = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_byte;

  // stimulus and scoreboard
  byte_t pend_bytes[$];
  byte_t exp_bytes[$];
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  bit    hold_go = 1'b0;
  logic  rx_hold = 1'b0;
  int    err_cnt = 0;

  // shadow copy of the whitener state
  byte_t     ring_mem [RING_COUNT][29];
  pos_t      rd_pos [RING_COUNT];
  ring_idx_t cur_ring;
  pos_t      cnt_left;

  prime_ring_xor_whitener u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte)
  );

  always #5 clk = ~clk;

  task automatic whiten_reset();
    for (int r = 0; r < RING_COUNT; r++) begin
      for (int i = 0; i < 29; i++) ring_mem[r][i] = '0;
      rd_pos[r] = '0;
    end
    cur_ring = '0;
    cnt_left = RING_LEN[0];
  endtask

  function automatic byte_t whiten_next(byte_t raw);
    byte_t mix;
    pos_t  wr_pos;
    mix = '0;
    wr_pos = rd_pos[cur_ring];
    for (int r = 0; r < RING_COUNT; r++) begin
      mix ^= ring_mem[r][rd_pos[r]];
      rd_pos[r] = (rd_pos[r] == '0) ? pos_t'(RING_LEN[r] - 1) : pos_t'(rd_pos[r] - 1);
    end
    ring_mem[cur_ring][wr_pos] = mix ^ raw;
    cnt_left = cnt_left - 1'b1;
    if (cnt_left == '0) begin
      cur_ring = (cur_ring == LAST_RING) ? ring_idx_t'(0) : ring_idx_t'(cur_ring + 1'b1);
      cnt_left = RING_LEN[cur_ring];
    end
    return mix;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
  endtask

  // sender
  always @(posedge clk) begin : drv
    bit take;
    if (rst) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
    end else if (!in_valid || in_ready) begin
      take = (pend_bytes.size() != 0) && ($urandom_range(99) >= tx_idle_pct);
      if (take) begin
        in_valid <= 1'b1;
        in_byte  <= pend_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // long receiver hold-off so the output queue fills and in_ready drops
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // input side predicts, output side checks against the oldest prediction
  always @(posedge clk) begin : mon
    byte_t want;
    if (rst) begin
      whiten_reset();
    end else begin
      if (in_valid && in_ready) exp_bytes.push_back(whiten_next(in_byte));
      if (out_valid && out_ready) begin
        if (exp_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected out_byte %02h", out_byte));
        end else begin
          want = exp_bytes.pop_front();
          if (out_byte !== want)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want));
        end
      end
    end
  end

  function automatic byte_t pick_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 8'h00;
    if (sel < 16) return 8'hff;
    return byte_t'($urandom);
  endfunction

  task automatic wait_drained();
    while (pend_bytes.size() != 0 || in_valid || exp_bytes.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int tx_pct, int rx_pct, bit with_hold);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (with_hold) begin
      repeat (PHASE_ITEMS / 2) pend_bytes.push_back(pick_byte());
      while (pend_bytes.size() > PHASE_ITEMS / 4) @(negedge clk);
      hold_go = 1'b1;
      repeat (PHASE_ITEMS / 2) pend_bytes.push_back(pick_byte());
    end else begin
      repeat (PHASE_ITEMS) pend_bytes.push_back(pick_byte());
    end
    // the phase waits here until every result is back
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero rings, extremes, walking ones and zeros
    pend_bytes.push_back(8'h00);
    pend_bytes.push_back(8'hff);
    pend_bytes.push_back(8'h00);
    pend_bytes.push_back(8'hff);
    pend_bytes.push_back(8'h55);
    pend_bytes.push_back(8'haa);
    for (int i = 0; i < 8; i++) pend_bytes.push_back(byte_t'(1) << i);
    for (int i = 0; i < 8; i++) pend_bytes.push_back(~(byte_t'(1) << i));
    pend_bytes.push_back(8'h80);
    pend_bytes.push_back(8'h01);
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(63, 0, 1'b0);
    run_phase(0, 63, 1'b0);
    run_phase(18, 18, 1'b0);

    repeat (10) @(negedge clk);
    if (err_cnt == 0 && exp_bytes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
